/* rtl/ecs_pkg.sv */
// Shared types, constants and codes for the eight-instruction CPU step block.
// Used by every module under rtl; depends on nothing else.
package ecs_pkg;

  localparam int MEM_WORDS = 65536;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int REG_COUNT = 8;
  localparam int REG_AW    = $clog2(REG_COUNT);
  localparam int WORD_W    = 32;
  localparam int PC_W      = 16;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [PC_W-1:0]   pc_t;

  // Instruction opcodes, bits 24..22 of the instruction word
  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_NAND = 3'd1,
    OP_LW   = 3'd2,
    OP_SW   = 3'd3,
    OP_BEQ  = 3'd4,
    OP_JALR = 3'd5,
    OP_HALT = 3'd6,
    OP_NOOP = 3'd7
  } opcode_t;

  // Item operation codes
  localparam logic OPER_LOAD = 1'b0;
  localparam logic OPER_STEP = 1'b1;

  typedef enum logic {
    ALU_ADD  = 1'b0,
    ALU_NAND = 1'b1
  } alu_op_t;

  // Result of the shared arithmetic unit
  typedef struct packed {
    logic [WORD_W:0] sum;      // sign-extended sum, one bit wider than a word
    word_t           nand_val;
    logic            equal;
  } alu_res_t;

endpackage

/* rtl/ecs_wmem.sv */
// Single-port word memory with registered read data.
// Depends on ecs_pkg for depth and word width.
module ecs_wmem (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic                      rd_en,
  input  logic [ecs_pkg::MEM_AW-1:0] addr,
  input  ecs_pkg::word_t            wr_data,
  output ecs_pkg::word_t            rd_data
);

  ecs_pkg::word_t mem_r [ecs_pkg::MEM_WORDS];
  ecs_pkg::word_t rd_data_r;

  // Write or read one word per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/ecs_regfile.sv */
// Eight-entry register file: two registered read ports, one write port.
// Per-entry valid bits make unwritten registers read as zero after reset.
// Depends on ecs_pkg.
module ecs_regfile (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [ecs_pkg::REG_AW-1:0] rd_addr_a,
  input  logic [ecs_pkg::REG_AW-1:0] rd_addr_b,
  output ecs_pkg::word_t            rd_data_a,
  output ecs_pkg::word_t            rd_data_b,
  input  logic                      wr_en,
  input  logic [ecs_pkg::REG_AW-1:0] wr_addr,
  input  ecs_pkg::word_t            wr_data
);

  ecs_pkg::word_t                  regs_r [ecs_pkg::REG_COUNT];
  logic [ecs_pkg::REG_COUNT-1:0]   valid_r;
  ecs_pkg::word_t                  rd_data_a_r;
  ecs_pkg::word_t                  rd_data_b_r;

  // Track which entries hold written data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Store the write data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      regs_r[wr_addr] <= wr_data;
    end
  end

  // Read both ports; an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a_r <= valid_r[rd_addr_a] ? regs_r[rd_addr_a] : '0;
      rd_data_b_r <= valid_r[rd_addr_b] ? regs_r[rd_addr_b] : '0;
    end
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

/* rtl/ecs_alu.sv */
// Shared arithmetic unit: add with carry-in, bitwise nand and equality.
// Serves register add and address sums; equality decides branches. Depends on ecs_pkg.
module ecs_alu (
  input  ecs_pkg::alu_op_t  op,
  input  ecs_pkg::word_t    opnd_a,
  input  ecs_pkg::word_t    opnd_b,
  input  logic              carry_in,
  output ecs_pkg::alu_res_t res
);

  logic [ecs_pkg::WORD_W:0] ext_a;
  logic [ecs_pkg::WORD_W:0] ext_b;

  // Sign-extend both operands so the sum keeps its sign
  assign ext_a = {opnd_a[ecs_pkg::WORD_W-1], opnd_a};
  assign ext_b = {opnd_b[ecs_pkg::WORD_W-1], opnd_b};

  always_comb begin
    res.sum      = ext_a + ext_b + {{ecs_pkg::WORD_W{1'b0}}, carry_in};
    res.nand_val = ~(opnd_a & opnd_b);
    res.equal    = (opnd_a == opnd_b);
    // Nand ignores the carry; the sum is still produced for address checks
    if (op == ecs_pkg::ALU_NAND) begin
      res.sum = ext_a + ext_b;
    end
  end

endmodule

/* rtl/eight_instruction_cpu_step.sv */
// Eight-instruction CPU step block: top level with the step sequencer.
// Depends on ecs_pkg, ecs_wmem, ecs_regfile and ecs_alu.
//
// Usage: the input channel (in_valid / in_stall) carries one item: a load
// (in_operation = 0) writes in_load_word to memory at in_load_address, a
// step (in_operation = 1) executes the instruction at the program counter.
// Each item returns exactly one result on the output channel
// (out_valid / out_stall): new pc, halt flag, executed count, the register
// or memory write made, and a fault flag.
// Sequence: a load passes through START and FINISH; a step that executes
// passes through START (fetch), DECODE, EXEC and FINISH, with LWDATA
// before FINISH for lw, paced by the single memory port that serves
// instruction fetch and data access in turn. A step after halt or with a
// faulting fetch goes from START straight to FINISH. One item is in work
// at a time, so the next transfer is taken once the sequencer is back in
// idle, even while the last result is still waiting on out_stall.
// Reset: registers, pc, halt and count clear at once; the word memory is
// then cleared by a pass over all MEM_WORDS words (65536), during which
// in_stall stays high.
// A stalled result holds on the outputs; a finished item waits in the
// sequencer until the output register is free.
module eight_instruction_cpu_step (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_operation,
  input  logic [15:0]          in_load_address,
  input  logic signed [31:0]   in_load_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          out_program_counter,
  output logic                 out_halted,
  output logic [31:0]          out_executed_count,
  output logic                 out_reg_written,
  output logic [2:0]           out_reg_index,
  output logic signed [31:0]   out_reg_value,
  output logic                 out_mem_written,
  output logic [15:0]          out_mem_address,
  output logic signed [31:0]   out_mem_value,
  output logic                 out_fault
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_START  = 7'b0000100,
    S_DECODE = 7'b0001000,
    S_EXEC   = 7'b0010000,
    S_LWDATA = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  localparam logic [ecs_pkg::MEM_AW-1:0] CLR_LAST = ecs_pkg::MEM_AW'(ecs_pkg::MEM_WORDS - 1);
  localparam logic [31:0] MEM_LIMIT = 32'(ecs_pkg::MEM_WORDS);

  state_t state_r, state_nxt;
  logic [ecs_pkg::MEM_AW-1:0] clr_cnt_r, clr_cnt_nxt;

  // Accepted item
  logic           op_r;
  ecs_pkg::pc_t   ld_addr_r;
  ecs_pkg::word_t ld_word_r;

  // Architectural state
  ecs_pkg::pc_t   pc_r, pc_nxt;
  logic           halt_r, halt_nxt;
  ecs_pkg::word_t cnt_r, cnt_nxt;
  ecs_pkg::word_t insn_r;

  // Pending result of the item in work
  logic                      res_rw_r, res_rw_nxt;
  logic [ecs_pkg::REG_AW-1:0] res_ri_r, res_ri_nxt;
  ecs_pkg::word_t            res_rv_r, res_rv_nxt;
  logic                      res_mw_r, res_mw_nxt;
  ecs_pkg::pc_t              res_ma_r, res_ma_nxt;
  ecs_pkg::word_t            res_mv_r, res_mv_nxt;
  logic                      res_flt_r, res_flt_nxt;
  logic                      res_done_r, res_done_nxt;
  logic                      res_halt_r, res_halt_nxt;
  ecs_pkg::pc_t              res_next_r, res_next_nxt;

  // Output register
  logic           out_valid_r;
  ecs_pkg::pc_t   out_pc_r;
  logic           out_halt_r;
  ecs_pkg::word_t out_cnt_r;
  logic           out_rw_r;
  logic [2:0]     out_ri_r;
  ecs_pkg::word_t out_rv_r;
  logic           out_mw_r;
  ecs_pkg::pc_t   out_ma_r;
  ecs_pkg::word_t out_mv_r;
  logic           out_flt_r;

  // Memory, register file and arithmetic unit hookup
  logic                       mem_we, mem_re;
  logic [ecs_pkg::MEM_AW-1:0] mem_addr;
  ecs_pkg::word_t             mem_wdata, mem_rdata;
  logic                       rf_re;
  ecs_pkg::word_t             rd_a, rd_b;
  ecs_pkg::alu_op_t           alu_op;
  ecs_pkg::word_t             alu_a, alu_b;
  logic                       alu_cin;
  ecs_pkg::alu_res_t          alu_res;

  // Decode of the held instruction
  ecs_pkg::opcode_t           opc;
  logic [ecs_pkg::REG_AW-1:0] fld_ra, fld_rb, fld_rd;
  ecs_pkg::word_t             off_ext;
  ecs_pkg::pc_t               pc_inc;
  ecs_pkg::word_t             pc_inc_w;
  logic                       addr_bad;

  logic in_xfer, finish_go;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign finish_go = (state_r == S_FINISH) && (!out_valid_r || !out_stall);

  assign opc      = ecs_pkg::opcode_t'(insn_r[24:22]);
  assign fld_ra   = insn_r[21:19];
  assign fld_rb   = insn_r[18:16];
  assign fld_rd   = insn_r[2:0];
  assign off_ext  = {{16{insn_r[15]}}, insn_r[15:0]};
  assign pc_inc   = pc_r + 16'd1;
  assign pc_inc_w = {15'd0, {1'b0, pc_r} + 17'd1};
  assign addr_bad = alu_res.sum[ecs_pkg::WORD_W]
                    || (alu_res.sum[ecs_pkg::WORD_W-1:0] >= MEM_LIMIT);

  // Select operands for the shared unit
  always_comb begin
    alu_op  = ecs_pkg::ALU_ADD;
    alu_a   = rd_a;
    alu_b   = off_ext;
    alu_cin = 1'b0;
    case (opc)
      ecs_pkg::OP_ADD: begin
        alu_b = rd_b;
      end
      ecs_pkg::OP_NAND: begin
        alu_op = ecs_pkg::ALU_NAND;
        alu_b  = rd_b;
      end
      ecs_pkg::OP_BEQ: begin
        alu_b = rd_b;
      end
      default: begin
        alu_a = rd_a;
      end
    endcase
  end

  // Drive the shared memory port
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = pc_r[ecs_pkg::MEM_AW-1:0];
    mem_wdata = res_mv_r;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt_r;
        mem_wdata = '0;
      end
      S_START: begin
        mem_re = (op_r == ecs_pkg::OPER_STEP);
      end
      S_EXEC: begin
        mem_re   = (opc == ecs_pkg::OP_LW);
        mem_addr = alu_res.sum[ecs_pkg::MEM_AW-1:0];
      end
      S_FINISH: begin
        mem_we   = finish_go && res_mw_r;
        mem_addr = res_ma_r[ecs_pkg::MEM_AW-1:0];
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  assign rf_re = (state_r == S_DECODE);

  // Sequencer and result build-up
  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    res_rw_nxt   = res_rw_r;
    res_ri_nxt   = res_ri_r;
    res_rv_nxt   = res_rv_r;
    res_mw_nxt   = res_mw_r;
    res_ma_nxt   = res_ma_r;
    res_mv_nxt   = res_mv_r;
    res_flt_nxt  = res_flt_r;
    res_done_nxt = res_done_r;
    res_halt_nxt = res_halt_r;
    res_next_nxt = res_next_r;
    pc_nxt       = pc_r;
    halt_nxt     = halt_r;
    cnt_nxt      = cnt_r;
    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        res_rw_nxt   = 1'b0;
        res_ri_nxt   = '0;
        res_rv_nxt   = '0;
        res_mw_nxt   = 1'b0;
        res_ma_nxt   = '0;
        res_mv_nxt   = '0;
        res_flt_nxt  = 1'b0;
        res_done_nxt = 1'b0;
        res_halt_nxt = 1'b0;
        res_next_nxt = pc_r;
        state_nxt    = S_FINISH;
        if (op_r == ecs_pkg::OPER_LOAD) begin
          if ({16'd0, ld_addr_r} < MEM_LIMIT) begin
            res_mw_nxt = 1'b1;
            res_ma_nxt = ld_addr_r;
            res_mv_nxt = ld_word_r;
          end else begin
            res_flt_nxt = 1'b1;
          end
        end else if (!halt_r) begin
          if ({16'd0, pc_r} >= MEM_LIMIT) begin
            res_flt_nxt = 1'b1;
          end else begin
            state_nxt = S_DECODE;
          end
        end
      end
      S_DECODE: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        res_done_nxt = 1'b1;
        res_next_nxt = pc_inc;
        state_nxt    = S_FINISH;
        case (opc)
          ecs_pkg::OP_ADD: begin
            res_rw_nxt = 1'b1;
            res_ri_nxt = fld_rd;
            res_rv_nxt = alu_res.sum[ecs_pkg::WORD_W-1:0];
          end
          ecs_pkg::OP_NAND: begin
            res_rw_nxt = 1'b1;
            res_ri_nxt = fld_rd;
            res_rv_nxt = alu_res.nand_val;
          end
          ecs_pkg::OP_LW: begin
            if (addr_bad) begin
              res_flt_nxt  = 1'b1;
              res_done_nxt = 1'b0;
            end else begin
              res_rw_nxt = 1'b1;
              res_ri_nxt = fld_rb;
              state_nxt  = S_LWDATA;
            end
          end
          ecs_pkg::OP_SW: begin
            if (addr_bad) begin
              res_flt_nxt  = 1'b1;
              res_done_nxt = 1'b0;
            end else begin
              res_mw_nxt = 1'b1;
              res_ma_nxt = alu_res.sum[15:0];
              res_mv_nxt = rd_b;
            end
          end
          ecs_pkg::OP_BEQ: begin
            // Taken target is pc + 1 + offset, kept to 16 bits
            if (alu_res.equal) begin
              res_next_nxt = pc_inc + insn_r[15:0];
            end
          end
          ecs_pkg::OP_JALR: begin
            res_rw_nxt   = 1'b1;
            res_ri_nxt   = fld_rb;
            res_rv_nxt   = pc_inc_w;
            // Same source and link register: the jump sees the link value
            res_next_nxt = (fld_ra == fld_rb) ? pc_inc : rd_a[15:0];
          end
          ecs_pkg::OP_HALT: begin
            res_halt_nxt = 1'b1;
          end
          default: begin
            res_halt_nxt = 1'b0;
          end
        endcase
      end
      S_LWDATA: begin
        res_rv_nxt = mem_rdata;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        if (finish_go) begin
          state_nxt = S_IDLE;
          if (res_done_r) begin
            pc_nxt = res_next_r;
            if (res_halt_r) begin
              halt_nxt = 1'b1;
            end
            if (cnt_r != '1) begin
              cnt_nxt = cnt_r + 32'd1;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      pc_r        <= '0;
      halt_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      pc_r      <= pc_nxt;
      halt_r    <= halt_nxt;
      cnt_r     <= cnt_nxt;
      if (finish_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r      <= in_operation;
      ld_addr_r <= in_load_address;
      ld_word_r <= $unsigned(in_load_word);
    end
    if (state_r == S_DECODE) begin
      insn_r <= mem_rdata;
    end
    res_rw_r   <= res_rw_nxt;
    res_ri_r   <= res_ri_nxt;
    res_rv_r   <= res_rv_nxt;
    res_mw_r   <= res_mw_nxt;
    res_ma_r   <= res_ma_nxt;
    res_mv_r   <= res_mv_nxt;
    res_flt_r  <= res_flt_nxt;
    res_done_r <= res_done_nxt;
    res_halt_r <= res_halt_nxt;
    res_next_r <= res_next_nxt;
    // Load the output register as the item finishes
    if (finish_go) begin
      out_pc_r   <= pc_nxt;
      out_halt_r <= halt_nxt;
      out_cnt_r  <= cnt_nxt;
      out_rw_r   <= res_rw_r;
      out_ri_r   <= res_ri_r;
      out_rv_r   <= res_rv_r;
      out_mw_r   <= res_mw_r;
      out_ma_r   <= res_ma_r;
      out_mv_r   <= res_mv_r;
      out_flt_r  <= res_flt_r;
    end
  end

  ecs_wmem u_wmem (
    .clk     (clk),
    .wr_en   (mem_we),
    .rd_en   (mem_re),
    .addr    (mem_addr),
    .wr_data (mem_wdata),
    .rd_data (mem_rdata)
  );

  ecs_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (rf_re),
    .rd_addr_a (mem_rdata[21:19]),
    .rd_addr_b (mem_rdata[18:16]),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b),
    .wr_en     (finish_go && res_rw_r),
    .wr_addr   (res_ri_r),
    .wr_data   (res_rv_r)
  );

  ecs_alu u_alu (
    .op       (alu_op),
    .opnd_a   (alu_a),
    .opnd_b   (alu_b),
    .carry_in (alu_cin),
    .res      (alu_res)
  );

  assign out_valid           = out_valid_r;
  assign out_program_counter = out_pc_r;
  assign out_halted          = out_halt_r;
  assign out_executed_count  = out_cnt_r;
  assign out_reg_written     = out_rw_r;
  assign out_reg_index       = out_ri_r;
  assign out_reg_value       = $signed(out_rv_r);
  assign out_mem_written     = out_mw_r;
  assign out_mem_address     = out_ma_r;
  assign out_mem_value       = $signed(out_mv_r);
  assign out_fault           = out_flt_r;

endmodule

/* sim/cpu_step_monitor.sv */
// Monitor for the eight-instruction CPU step block: keeps a shadow machine,
// queues the outcome of every input transfer and checks each result transfer.
// Depends on ecs_pkg.
`timescale 1ns / 100ps

module cpu_step_monitor
  import ecs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_operation,
  input  logic [15:0] in_load_address,
  input  logic [31:0] in_load_word,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_program_counter,
  input  logic        out_halted,
  input  logic [31:0] out_executed_count,
  input  logic        out_reg_written,
  input  logic [2:0]  out_reg_index,
  input  logic [31:0] out_reg_value,
  input  logic        out_mem_written,
  input  logic [15:0] out_mem_address,
  input  logic [31:0] out_mem_value,
  input  logic        out_fault,
  output int          errors,
  output int          waiting,
  output pc_t         model_pc
);

  localparam int REPORT_MAX = 10;

  typedef struct packed {
    pc_t        pc;
    logic       halted;
    word_t      count;
    logic       reg_wr;
    logic [2:0] reg_idx;
    word_t      reg_val;
    logic       mem_wr;
    pc_t        mem_addr;
    word_t      mem_val;
    logic       fault;
  } outcome_t;

  // Shadow machine state
  word_t             regs [REG_COUNT];
  bit [WORD_W-1:0]   mem [MEM_WORDS];
  pc_t               pc_q;
  logic              halt_q;
  word_t             count_q;

  outcome_t owed_outcomes [$];
  outcome_t got;
  outcome_t want;
  int       mismatches;

  // Apply one item to the shadow machine and return what the block must report
  function automatic outcome_t apply_item(input logic oper, input pc_t addr, input word_t word);
    outcome_t   o;
    word_t      insn;
    opcode_t    opc;
    logic [2:0] ra;
    logic [2:0] rb;
    pc_t        next_pc;
    longint     daddr;
    logic       commit;
    o = '0;
    if (oper == OPER_LOAD) begin
      if (int'(addr) < MEM_WORDS) begin
        mem[addr]  = word;
        o.mem_wr   = 1'b1;
        o.mem_addr = addr;
        o.mem_val  = word;
      end else begin
        o.fault = 1'b1;
      end
    end else if (!halt_q) begin
      if (int'(pc_q) >= MEM_WORDS) begin
        o.fault = 1'b1;
      end else begin
        insn    = mem[pc_q];
        opc     = opcode_t'(insn[24:22]);
        ra      = insn[21:19];
        rb      = insn[18:16];
        next_pc = pc_q + 16'd1;
        daddr   = longint'($signed(regs[ra])) + longint'($signed(insn[15:0]));
        commit  = 1'b1;
        case (opc)
          OP_ADD: begin
            o.reg_wr  = 1'b1;
            o.reg_idx = insn[2:0];
            o.reg_val = regs[ra] + regs[rb];
          end
          OP_NAND: begin
            o.reg_wr  = 1'b1;
            o.reg_idx = insn[2:0];
            o.reg_val = ~(regs[ra] & regs[rb]);
          end
          OP_LW, OP_SW: begin
            // Data address is the full signed sum; out of memory drops the step
            if (daddr < 0 || daddr >= MEM_WORDS) begin
              o.fault = 1'b1;
              commit  = 1'b0;
            end else if (opc == OP_LW) begin
              o.reg_wr  = 1'b1;
              o.reg_idx = rb;
              o.reg_val = mem[daddr[MEM_AW-1:0]];
            end else begin
              o.mem_wr   = 1'b1;
              o.mem_addr = daddr[MEM_AW-1:0];
              o.mem_val  = regs[rb];
            end
          end
          OP_BEQ: begin
            if (regs[ra] == regs[rb]) next_pc = pc_q + 16'd1 + insn[15:0];
          end
          OP_JALR: begin
            // Link first, so regA == regB jumps to the next word
            o.reg_wr  = 1'b1;
            o.reg_idx = rb;
            o.reg_val = word_t'(pc_q) + 32'd1;
            regs[rb]  = o.reg_val;
            next_pc   = regs[ra][PC_W-1:0];
          end
          OP_HALT: halt_q = 1'b1;
          default: ;
        endcase
        if (commit) begin
          if (o.reg_wr) regs[o.reg_idx] = o.reg_val;
          if (o.mem_wr) mem[o.mem_addr] = o.mem_val;
          pc_q = next_pc;
          if (count_q != '1) count_q = count_q + 32'd1;
        end
      end
    end
    o.pc     = pc_q;
    o.halted = halt_q;
    o.count  = count_q;
    return o;
  endfunction

  function automatic string describe(input outcome_t o);
    return $sformatf("pc %h halt %b count %0d reg %b/%0d/%h mem %b/%h/%h fault %b",
                     o.pc, o.halted, o.count, o.reg_wr, o.reg_idx, o.reg_val,
                     o.mem_wr, o.mem_addr, o.mem_val, o.fault);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) regs[i] = '0;
      pc_q    = '0;
      halt_q  = 1'b0;
      count_q = '0;
      owed_outcomes.delete();
      mismatches = 0;
    end else begin
      // Check the result transfer before queuing a new outcome
      if (out_valid && !out_stall) begin
        got = {out_program_counter, out_halted, out_executed_count, out_reg_written,
               out_reg_index, out_reg_value, out_mem_written, out_mem_address,
               out_mem_value, out_fault};
        if (owed_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: result with nothing outstanding: %s", $realtime, describe(got));
        end else begin
          want = owed_outcomes.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
          end
        end
      end
      if (in_valid && !in_stall)
        owed_outcomes.push_back(apply_item(in_operation, in_load_address, in_load_word));
    end
    errors   <= mismatches;
    waiting  <= owed_outcomes.size();
    model_pc <= pc_q;
  end

endmodule

/* sim/eight_instruction_cpu_step_test.sv */
// Top of the CPU step regression: clock, reset, directed and random programs,
// receiver back-pressure and the verdict. Depends on ecs_pkg,
// eight_instruction_cpu_step and cpu_step_monitor.
`timescale 1ns / 100ps

module eight_instruction_cpu_step_test;
  import ecs_pkg::*;

  localparam int ITEM_TARGET    = 1900;
  localparam int SQUEEZE_AT     = 1000;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 20;
  // Covers the memory clearing pass after reset several times over
  localparam int WATCHDOG_LIMIT = 4 * MEM_WORDS;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_operation;
  logic [15:0] in_load_address;
  logic [31:0] in_load_word;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_program_counter;
  logic        out_halted;
  logic [31:0] out_executed_count;
  logic        out_reg_written;
  logic [2:0]  out_reg_index;
  logic [31:0] out_reg_value;
  logic        out_mem_written;
  logic [15:0] out_mem_address;
  logic [31:0] out_mem_value;
  logic        out_fault;

  int  errors;
  int  waiting;
  pc_t model_pc;
  int  items_sent;
  int  idle_cycles;
  bit  send_quiet;
  bit  hold_go;

  always #2 clk = ~clk;

  eight_instruction_cpu_step dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_load_address     (in_load_address),
    .in_load_word        (in_load_word),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_program_counter (out_program_counter),
    .out_halted          (out_halted),
    .out_executed_count  (out_executed_count),
    .out_reg_written     (out_reg_written),
    .out_reg_index       (out_reg_index),
    .out_reg_value       (out_reg_value),
    .out_mem_written     (out_mem_written),
    .out_mem_address     (out_mem_address),
    .out_mem_value       (out_mem_value),
    .out_fault           (out_fault)
  );

  cpu_step_monitor monitor (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_load_address     (in_load_address),
    .in_load_word        (in_load_word),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_program_counter (out_program_counter),
    .out_halted          (out_halted),
    .out_executed_count  (out_executed_count),
    .out_reg_written     (out_reg_written),
    .out_reg_index       (out_reg_index),
    .out_reg_value       (out_reg_value),
    .out_mem_written     (out_mem_written),
    .out_mem_address     (out_mem_address),
    .out_mem_value       (out_mem_value),
    .out_fault           (out_fault),
    .errors              (errors),
    .waiting             (waiting),
    .model_pc            (model_pc)
  );

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stall after each transfer, one long hold on request
  initial begin
    int gap;
    bit quiet;
    bit hold_taken;
    out_stall  = 1'b0;
    gap        = 0;
    quiet      = 1'b0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if ($urandom_range(0, 39) == 0) quiet = !quiet;
        gap = quiet ? 0 : $urandom_range(0, 8);
      end
      @(negedge clk);
      if (!hold_go) hold_taken = 1'b0;
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        gap--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one item after a random gap and hold it until the transfer.
  // Returns at the next falling edge with valid still high; the caller
  // sends again or drains in that same step.
  task automatic send_item(input logic oper, input pc_t addr, input word_t word);
    int gap;
    if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= oper;
    in_load_address <= addr;
    in_load_word    <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (waiting != 0) @(negedge clk);
  endtask

  function automatic word_t encode(input opcode_t opc, input logic [2:0] ra,
                                   input logic [2:0] rb, input logic [15:0] off);
    return {7'b0, opc, ra, rb, off};
  endfunction

  // Never yield a halt: it would freeze the machine for the rest of the run
  function automatic word_t no_halt(input word_t word);
    word_t w;
    w = word;
    if (w[24:22] == OP_HALT) w[22] = 1'b1;
    return w;
  endfunction

  function automatic word_t random_insn();
    word_t       noise;
    opcode_t     opc;
    logic [15:0] off;
    noise = $urandom;
    off   = 16'($urandom);
    case ($urandom_range(0, 6))
      0:       opc = OP_ADD;
      1:       opc = OP_NAND;
      2:       opc = OP_LW;
      3:       opc = OP_SW;
      4:       opc = OP_BEQ;
      5:       opc = OP_JALR;
      default: opc = OP_NOOP;
    endcase
    // Keep most data accesses near the low words that hold loaded data
    if ((opc == OP_LW || opc == OP_SW) && $urandom_range(0, 3) != 0)
      off = 16'($urandom_range(0, 255));
    if (opc == OP_BEQ && $urandom_range(0, 1) == 0)
      off = 16'($urandom_range(0, 16) - 8);
    return {noise[31:25], opc, noise[21:16], off};
  endfunction

  // Place an instruction where the machine will fetch next, then step it
  task automatic run_insn(input word_t insn);
    send_item(OPER_LOAD, model_pc, insn);
    send_item(OPER_STEP, pc_t'($urandom), $urandom);
  endtask

  // Force a register to zero: t = ~s, t = s + ~s = -1, t = ~(-1 & -1) = 0
  task automatic zero_register(input logic [2:0] t);
    logic [2:0] s;
    s = t + 3'd1;
    run_insn(encode(OP_NAND, s, s, {13'b0, t}));
    run_insn(encode(OP_ADD, s, t, {13'b0, t}));
    run_insn(encode(OP_NAND, t, t, {13'b0, t}));
  endtask

  // Hold the receiver off while the sender keeps offering work
  task automatic squeeze();
    hold_go <= 1'b1;
    repeat (6) run_insn(random_insn());
    wait_drain();
    hold_go <= 1'b0;
  endtask

  initial begin
    int pick;
    bit squeezed;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_operation    = OPER_LOAD;
    in_load_address = '0;
    in_load_word    = '0;
    hold_go         = 1'b0;
    send_quiet      = 1'b0;
    items_sent      = 0;
    idle_cycles     = 0;
    squeezed        = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed program: field extremes and every instruction but halt
    send_item(OPER_LOAD, 16'd100, 32'h8000_0000);
    run_insn(encode(OP_LW, 3'd0, 3'd1, 16'd100));     // r1 = most negative word
    run_insn(encode(OP_LW, 3'd0, 3'd2, 16'hFFFF));    // address -1 faults
    run_insn(encode(OP_ADD, 3'd1, 3'd1, 16'd3));      // sum wraps to zero
    run_insn(encode(OP_NAND, 3'd1, 3'd0, 16'd4));     // all ones
    run_insn(encode(OP_NAND, 3'd1, 3'd1, 16'd5));     // most positive word
    run_insn(encode(OP_SW, 3'd5, 3'd1, 16'd0));       // far above memory faults
    run_insn(encode(OP_SW, 3'd0, 3'd1, 16'd200));
    run_insn(encode(OP_BEQ, 3'd0, 3'd3, 16'd5));      // equal: taken
    run_insn(encode(OP_BEQ, 3'd1, 3'd0, 16'd5));      // not equal: falls through
    run_insn(encode(OP_JALR, 3'd6, 3'd6, 16'd0));     // same register: next word
    run_insn(encode(OP_JALR, 3'd4, 3'd7, 16'd0));     // jump to the last word
    run_insn({7'h7F, OP_NOOP, 22'h3F_FFFF});          // pc wraps back to zero

    squeeze();

    // Random programs with some stray loads and plain steps mixed in
    while (items_sent < ITEM_TARGET) begin
      if (!squeezed && items_sent >= SQUEEZE_AT) begin
        squeeze();
        squeezed = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55)
        run_insn(random_insn());
      else if (pick < 70)
        send_item(OPER_STEP, pc_t'($urandom), $urandom);
      else if (pick < 85)
        send_item(OPER_LOAD, pc_t'($urandom_range(0, 255)),
                  ($urandom_range(0, 3) == 0) ? no_halt($urandom) : $urandom_range(0, 300));
      else if (pick < 90)
        send_item(OPER_LOAD, pc_t'($urandom), no_halt($urandom));
      else
        zero_register(3'($urandom_range(0, 7)));
    end

    // Halt, then show that steps are frozen and loads still land
    run_insn(encode(OP_HALT, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 16'd0));
    send_item(OPER_STEP, pc_t'($urandom), $urandom);
    send_item(OPER_LOAD, pc_t'($urandom), $urandom);
    send_item(OPER_STEP, pc_t'($urandom), $urandom);

    wait_drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0 && waiting == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
